// ----- hdl/scrambled_halton_hammersley_sample_core_assert.svh -----
// assertion macros used by the sample core controller
`ifndef SCRAMBLED_HALTON_HAMMERSLEY_SAMPLE_CORE_ASSERT_SVH
`define SCRAMBLED_HALTON_HAMMERSLEY_SAMPLE_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define SHHS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SHHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/shhs_pkg.sv -----
// shared constants, types and prime table of the sample core
package shhs_pkg;

  localparam int PRIME_COUNT_DEF   = 32;
  localparam int ROW_LENGTH_DEF    = 256;
  localparam int FRACTION_BITS_DEF = 32;

  localparam int IDX_W     = 31;
  localparam int SUM_W     = 32;
  localparam int DIM_W     = 8;
  localparam int TSLOT_W   = 5;
  localparam int TDIGIT_W  = 8;
  localparam int VAL_W     = 8;
  localparam int OUT_W     = 32;
  localparam int BASE_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;
  localparam int ROM_SIZE  = 100;
  localparam int ROM_IDX_W = 7;

  // denominator is at most base * sum, numerator at most 255 times that
  localparam int DEN_W = SUM_W + BASE_W;
  localparam int NUM_W = DEN_W + VAL_W;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;
  localparam logic MODE_HALTON = 1'b0;

  localparam logic [BASE_W-1:0] PRIME_ROM [ROM_SIZE] = '{
      10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,  10'd23,  10'd29,
      10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,  10'd59,  10'd61,  10'd67,  10'd71,
      10'd73,  10'd79,  10'd83,  10'd89,  10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113,
      10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
      10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223, 10'd227, 10'd229,
      10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263, 10'd269, 10'd271, 10'd277, 10'd281,
      10'd283, 10'd293, 10'd307, 10'd311, 10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349,
      10'd353, 10'd359, 10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
      10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463,
      10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541
  };

  function automatic logic [BASE_W-1:0] prime_at(input logic [ROM_IDX_W-1:0] i);
    logic [BASE_W-1:0] p;
    if (i < ROM_IDX_W'(ROM_SIZE)) begin
      p = PRIME_ROM[i];
    end else begin
      p = PRIME_ROM[0];
    end
    return p;
  endfunction

  typedef struct packed {
    logic load_wr;
    logic capture;
    logic init_first;
    logic init_digits;
    logic mod_start;
    logic mod_take;
    logic dig_start;
    logic mem_read;
    logic acc;
    logic frac_init;
    logic frac_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic need_mod;
    logic rest_zero;
    logic div_busy;
    logic ovf;
    logic frac_last;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/shhs_div.sv -----
// restoring divider, one quotient bit per cycle
module shhs_div
  import shhs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CFG_W-1:0] divisor,
  output logic             busy,
  output logic [SUM_W-1:0] quotient,
  output logic [CFG_W-1:0] remainder
);

  localparam int CNT_W = $clog2(SUM_W);

  logic [SUM_W-1:0] dq;
  logic [CFG_W-1:0] rem;
  logic [CFG_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] trial;
  logic             ge;

  assign trial = {rem, dq[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(SUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[SUM_W-2:0], ge};
      rem <= ge ? CFG_W'(trial - {1'b0, dvs}) : trial[CFG_W-1:0];
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

endmodule

// ----- hdl/shhs_dp.sv -----
// datapath: config registers, permutation memory, digit accumulation, fraction loop
module shhs_dp
  import shhs_pkg::*;
#(
  parameter int PRIME_COUNT   = PRIME_COUNT_DEF,
  parameter int ROW_LENGTH    = ROW_LENGTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [IDX_W-1:0]     sample_index,
  input  logic [DIM_W-1:0]     dimension,
  input  logic [TSLOT_W-1:0]   table_slot,
  input  logic [TDIGIT_W-1:0]  table_digit,
  input  logic [VAL_W-1:0]     table_value,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     fraction,
  output logic                 dim_clamped,
  output logic                 saturated
);

  localparam int DEPTH = PRIME_COUNT * ROW_LENGTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(PRIME_COUNT);
  localparam int CW    = $clog2(FRACTION_BITS);

  // configuration
  logic             seq_mode;
  logic [CFG_W-1:0] index_offset;
  logic [CFG_W-1:0] sample_count;
  logic [CFG_W-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_mode     <= MODE_HALTON;
      index_offset <= '0;
      sample_count <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   seq_mode     <= cfg_data[0];
        REG_OFFSET: index_offset <= cfg_data;
        REG_COUNT:  sample_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_eff = (sample_count == '0) ? CFG_W'(1) : sample_count;

  // item capture: offset sum and dimension clamp
  logic [SUM_W-1:0] sum_in;
  logic [DIM_W-1:0] pc8;
  logic [DIM_W-1:0] dim_eff;
  logic [DIM_W-1:0] slot8;
  logic             clamp_in;
  logic             first_in;

  assign sum_in = {1'b0, sample_index} + {1'b0, index_offset};
  assign pc8    = DIM_W'(PRIME_COUNT);

  always_comb begin
    clamp_in = 1'b0;
    dim_eff  = dimension;
    if (seq_mode == MODE_HALTON) begin
      if (dimension == '0) begin
        dim_eff  = DIM_W'(1);
        clamp_in = 1'b1;
      end else if (dimension >= pc8) begin
        dim_eff  = pc8 - 1'b1;
        clamp_in = 1'b1;
      end
      slot8    = dim_eff;
      first_in = 1'b0;
    end else begin
      if (dimension == '0) begin
        dim_eff  = DIM_W'(1);
        clamp_in = 1'b1;
      end else if (dimension > pc8) begin
        dim_eff  = pc8;
        clamp_in = 1'b1;
      end
      slot8    = dim_eff - 1'b1;
      first_in = dim_eff == DIM_W'(1);
    end
  end

  logic [SUM_W-1:0]  sum_r;
  logic [SW-1:0]     slot_r;
  logic              clamp_r;
  logic              first_r;
  logic [BASE_W-1:0] base;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sum_r   <= sum_in;
      slot_r  <= SW'(slot8);
      clamp_r <= clamp_in;
      first_r <= first_in;
    end
  end

  assign base = prime_at(ROM_IDX_W'(slot_r));

  // divider shared by the index wrap and the digit peel
  logic [SUM_W-1:0] rest;
  logic [SUM_W-1:0] div_quo;
  logic [CFG_W-1:0] div_rem;
  logic             div_busy;

  shhs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mod_start | cmd.dig_start),
    .dividend  (cmd.mod_start ? sum_r : rest),
    .divisor   (cmd.mod_start ? n_eff : CFG_W'(base)),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // permutation memory
  logic [VAL_W-1:0] perm_mem [DEPTH];
  logic [VAL_W-1:0] perm_r;
  logic             in_row_r;
  logic             in_row;
  logic             wr_ok;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  assign wr_ok   = (32'(table_slot) < PRIME_COUNT) && (32'(table_digit) < ROW_LENGTH);
  assign wr_addr = AW'(32'(table_slot) * 32'(ROW_LENGTH) + 32'(table_digit));
  assign in_row  = 32'(div_rem) < ROW_LENGTH;
  assign rd_addr = in_row ? AW'(32'(slot_r) * 32'(ROW_LENGTH) + 32'(div_rem)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_wr && wr_ok) begin
      perm_mem[wr_addr] <= table_value;
    end
    if (cmd.mem_read) begin
      perm_r   <= perm_mem[rd_addr];
      in_row_r <= in_row;
    end
  end

  // numerator / denominator accumulation
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [VAL_W-1:0] perm_eff;

  assign perm_eff = in_row_r ? perm_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.init_first) begin
      num <= NUM_W'(sum_r);
      den <= DEN_W'(n_eff);
    end else if (cmd.init_digits) begin
      rest <= sum_r;
      num  <= '0;
      den  <= DEN_W'(1);
    end else if (cmd.mod_take) begin
      rest <= {1'b0, div_rem};
      num  <= '0;
      den  <= DEN_W'(1);
    end else if (cmd.mem_read) begin
      rest <= div_quo;
    end else if (cmd.acc) begin
      num <= NUM_W'(num * base) + NUM_W'(perm_eff);
      den <= DEN_W'(den * base);
    end
  end

  // fraction long division
  logic [DEN_W-1:0]         rmd;
  logic [FRACTION_BITS-1:0] q;
  logic [CW-1:0]            fcnt;
  logic                     sat_r;
  logic [DEN_W:0]           rmd2;
  logic                     fge;
  logic [OUT_W-1:0]         conv;

  assign rmd2 = {rmd, 1'b0};
  assign fge  = rmd2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.frac_init) begin
      sat_r <= stat.ovf;
      rmd   <= DEN_W'(num);
      q     <= '0;
      fcnt  <= '0;
    end else if (cmd.frac_step) begin
      rmd  <= fge ? DEN_W'(rmd2 - {1'b0, den}) : DEN_W'(rmd2);
      q    <= {q[FRACTION_BITS-2:0], fge};
      fcnt <= fcnt + 1'b1;
    end
  end

  generate
    if (FRACTION_BITS >= OUT_W) begin : g_narrow
      assign conv = q[FRACTION_BITS-1 -: OUT_W];
    end else begin : g_widen
      assign conv = {q, {(OUT_W - FRACTION_BITS){1'b0}}};
    end
  endgenerate

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fraction    <= sat_r ? '1 : conv;
      dim_clamped <= clamp_r;
      saturated   <= sat_r;
    end
  end

  assign stat.first     = first_r;
  assign stat.need_mod  = (seq_mode != MODE_HALTON) && !first_r && (sum_r >= {1'b0, n_eff});
  assign stat.rest_zero = rest == '0;
  assign stat.div_busy  = div_busy;
  assign stat.ovf       = num >= NUM_W'(den);
  assign stat.frac_last = fcnt == CW'(FRACTION_BITS - 1);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ----- hdl/shhs_ctrl.sv -----
// controller state machine sequencing one word through the datapath
module shhs_ctrl
  import shhs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_kind,
  output logic  in_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  `include "scrambled_halton_hammersley_sample_core_assert.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_LOOP  = 4'd3;
  localparam logic [3:0] S_DIG   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_FINIT = 4'd6;
  localparam logic [3:0] S_FRAC  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        // no word is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        if (stat.first) begin
          cmd.init_first = 1'b1;
          state_next     = S_FINIT;
        end else if (stat.need_mod) begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end else begin
          cmd.init_digits = 1'b1;
          state_next      = S_LOOP;
        end
      end
      S_MOD: begin
        if (!stat.div_busy) begin
          cmd.mod_take = 1'b1;
          state_next   = S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat.rest_zero) begin
          state_next = S_FINIT;
        end else begin
          cmd.dig_start = 1'b1;
          state_next    = S_DIG;
        end
      end
      S_DIG: begin
        if (!stat.div_busy) begin
          cmd.mem_read = 1'b1;
          state_next   = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_LOOP;
      end
      S_FINIT: begin
        cmd.frac_init = 1'b1;
        state_next    = stat.ovf ? S_DONE : S_FRAC;
      end
      S_FRAC: begin
        cmd.frac_step = 1'b1;
        if (stat.frac_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `SHHS_ASSERT_NEXT(a_dig_to_acc, (state == S_DIG) && !stat.div_busy, state == S_ACC,
                    "digit divide done but no accumulate followed")
  `SHHS_ASSERT_NEXT(a_done_to_idle, (state == S_DONE) && stat.out_free, state == S_IDLE,
                    "result loaded but controller did not return to idle")
  `SHHS_ASSERT_NEXT(a_sample_leaves_idle,
                    (state == S_IDLE) && in_valid && (in_kind == KIND_SAMPLE),
                    state == S_SETUP, "sample word accepted but not started")
  `SHHS_ASSERT_SAME(a_div_idle_when_waiting, (state == S_LOOP) || (state == S_ACC),
                    !stat.div_busy, "divider busy outside a divide wait")

endmodule

// ----- hdl/scrambled_halton_hammersley_sample_core.sv -----
// top level of the scrambled halton / hammersley sample core
//
//  channel  dir  handshake          contents
//  s_*      in   s_tvalid/s_tready  tdata: sample_index, dimension, table_slot,
//                                   table_digit, table_value; tuser: kind
//  m_*      out  m_tvalid/m_tready  tdata: fraction; tuser: dim_clamped, saturated
//  cfg_*    in   cfg_we             cfg_index selects register, cfg_data value
//
// a load word is handled in idle and writes the permutation memory. a sample word takes one
// bit-serial divide per base-b digit of its index, plus one more for the
// index wrap when hammersley reduces it, plus the fraction long division and
// setup. rst is synchronous; the permutation memory is not cleared.
// the result register lets the next word be taken while a result waits on m_tready.
module scrambled_halton_hammersley_sample_core
  import shhs_pkg::*;
#(
  parameter int PRIME_COUNT   = PRIME_COUNT_DEF,
  parameter int ROW_LENGTH    = ROW_LENGTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [30:0] sample_index, [38:31] dimension, [43:39] table_slot,
  // [51:44] table_digit, [59:52] table_value, [63:60] zero
  input  logic [63:0]          s_tdata,
  // [0] kind
  input  logic [0:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [31:0] fraction
  output logic [OUT_W-1:0]     m_tdata,
  // [0] dim_clamped, [1] saturated
  output logic [1:0]           m_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  shhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser[0]),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  shhs_dp #(
    .PRIME_COUNT   (PRIME_COUNT),
    .ROW_LENGTH    (ROW_LENGTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_index (s_tdata[30:0]),
    .dimension    (s_tdata[38:31]),
    .table_slot   (s_tdata[43:39]),
    .table_digit  (s_tdata[51:44]),
    .table_value  (s_tdata[59:52]),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .fraction     (m_tdata),
    .dim_clamped  (m_tuser[0]),
    .saturated    (m_tuser[1])
  );

endmodule
